### rtl/eccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eccs_pkg
// Shared types and constants for the enclosing circle centre search.
// ----------------------------------------------------------------------------
package eccs_pkg;
	localparam int COORD_W = 32;
	localparam int SQ_W    = 66;
	localparam int ROOT_W  = 33;
	localparam int PROD_W  = 64;

	localparam logic [0:0] REG_AREA_WIDTH  = 1'd0;
	localparam logic [0:0] REG_AREA_HEIGHT = 1'd1;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   last_point;
	} point_t;

	typedef struct packed {
		coord_t center_x;
		coord_t center_y;
		coord_t radius;
		logic   points_dropped;
	} result_t;

	// request to the shared sequential unit
	typedef struct packed {
		logic            start;
		logic            is_div;
		logic [SQ_W-1:0] opa;
		logic [PROD_W-1:0] opb;
	} unit_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] res;
	} unit_rsp_t;
endpackage

### rtl/eccs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eccs_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface eccs_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/eccs_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eccs_unit
// Shared iterative unit: 66-bit floor square root (two bits per cycle) or
// 64/64 restoring divide (one bit per cycle).
// ----------------------------------------------------------------------------
module eccs_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  eccs_pkg::unit_req_t req,
	output eccs_pkg::unit_rsp_t rsp
);
	import eccs_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic              div_q;
	logic [6:0]        cnt_q;
	logic [SQ_W-1:0]   num_q;
	logic [PROD_W-1:0] den_q;
	logic [PROD_W+1:0] rem_q;
	logic [PROD_W-1:0] root_q;
	logic [PROD_W+1:0] rem_sh;
	logic [PROD_W+1:0] trial;
	logic [PROD_W+1:0] drem;

	always_comb begin
		rem_sh = {rem_q[PROD_W-1:0], num_q[SQ_W-1:SQ_W-2]};
		trial  = {root_q, 2'b01};
		drem   = {rem_q[PROD_W:0], num_q[SQ_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				div_q  <= req.is_div;
				num_q  <= req.opa;
				den_q  <= req.opb;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= req.is_div ? 7'd64 : 7'd33;
			end else if (busy_q) begin
				if (div_q) begin
					num_q <= {num_q[SQ_W-2:0], 1'b0};
					if (drem >= {2'b00, den_q}) begin
						rem_q  <= drem - {2'b00, den_q};
						root_q <= {root_q[PROD_W-2:0], 1'b1};
					end else begin
						rem_q  <= drem;
						root_q <= {root_q[PROD_W-2:0], 1'b0};
					end
				end else begin
					num_q <= {num_q[SQ_W-3:0], 2'b00};
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[PROD_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[PROD_W-2:0], 1'b0};
					end
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// root_q holds the final value for as long as the unit stays idle
	assign rsp = {done_q, root_q};

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("unit done without work");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("unit started while busy");
	a_cnt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 7'd0) else $error("unit count underflow");
`endif
endmodule

### rtl/eccs_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eccs_store
// Point memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module eccs_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  eccs_pkg::coord_t wx,
	input  eccs_pkg::coord_t wy,
	input  logic [AW-1:0]   raddr,
	output eccs_pkg::coord_t rx,
	output eccs_pkg::coord_t ry
);
	import eccs_pkg::*;

	coord_t mem_x [DEPTH];
	coord_t mem_y [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[waddr] <= wx;
			mem_y[waddr] <= wy;
		end
		rx <= mem_x[raddr];
		ry <= mem_y[raddr];
	end
endmodule

### rtl/enclosing_circle_center_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enclosing_circle_center_search
// Approximate minimax center of a stored point set.
// ----------------------------------------------------------------------------
// Points load at one per cycle. The point marked last starts a search that
// holds the input not ready until the result is registered; a new set may
// load while that result waits to be taken. A search runs a start step root,
// a first scan and root, and the output once, and in each round a scan (one
// 32x32 multiply pair per point, registered), a square root and two divides
// on one shared iterative unit, and bookkeeping. A round whose farthest
// distance is zero skips the divides. Rounds number about 6.6*log2 of the
// start step plus nine.
// ----------------------------------------------------------------------------
module enclosing_circle_center_search #(
	parameter int MAX_POINTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	eccs_if.sink        in_ch,
	eccs_if.source      out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import eccs_pkg::*;

	localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW  = $clog2(MAX_POINTS + 1);

	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_INIT  = 4'd1;
	localparam logic [3:0] ST_ISQ   = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_RSQ   = 4'd4;
	localparam logic [3:0] ST_RDP   = 4'd5;
	localparam logic [3:0] ST_DIVX  = 4'd6;
	localparam logic [3:0] ST_DIVY  = 4'd7;
	localparam logic [3:0] ST_STEP  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;
	localparam logic [3:0] ST_MULW  = 4'd10;
	localparam logic [3:0] ST_DIV10 = 4'd11;

	coord_t     area_w_q, area_h_q;
	logic [3:0] st_q;
	logic [CW-1:0] cnt_q;
	logic       ovf_q;
	coord_t     cx_q, cy_q, step_q;
	logic       rounds_q;
	logic [CW-1:0] k_q;
	logic       rv_s1, rv_s2;
	logic [CW-1:0] ki_s1;
	logic [AW-1:0] ki_s2;
	logic [SQ_W-1:0] best_q;
	logic [AW-1:0] bidx_q;
	logic       any_q;
	coord_t     bx_q, by_q;
	logic [PROD_W-1:0] e_q;
	logic [PROD_W-1:0] mx_q, my_q;
	logic [PROD_W-1:0] wsq_q;
	coord_t     rad_q;
	coord_t     q10_q;
	result_t    res_q;
	logic       ovalid_q;
	unit_req_t  ureq;
	unit_rsp_t  ursp;
	coord_t     rx, ry;
	logic [AW-1:0] raddr;
	logic       acc;
	logic [31:0] dx, dy;
	logic [PROD_W-1:0] dx2, dy2;
	logic [SQ_W-1:0] dsum;
	logic [32:0] nxt;
	logic [63:0] q10_p;
	coord_t     q10x10, rem10, step_nx;
	logic       u_busy;
	logic       divx_go_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_w_q <= '0;
			area_h_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_AREA_WIDTH:  area_w_q <= pwdata;
				REG_AREA_HEIGHT: area_h_q <= pwdata;
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[2])
			REG_AREA_WIDTH:  prdata = area_w_q;
			REG_AREA_HEIGHT: prdata = area_h_q;
			default:         prdata = '0;
		endcase
	end

	assign in_ch.ready = (st_q == ST_LOAD);
	assign acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = res_q;

	assign raddr = (st_q == ST_SCAN) ? k_q[AW-1:0] : bidx_q;

	eccs_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store (
		.clk(clk), .we(acc && (cnt_q < CW'(MAX_POINTS))), .waddr(cnt_q[AW-1:0]),
		.wx(in_ch.data.point_x), .wy(in_ch.data.point_y),
		.raddr(raddr), .rx(rx), .ry(ry));

	eccs_unit u_unit (.clk(clk), .arst_n(arst_n), .req(ureq), .rsp(ursp));

	// stage 2: squared distance
	assign dx = (rx > cx_q) ? rx - cx_q : cx_q - rx;
	assign dy = (ry > cy_q) ? ry - cy_q : cy_q - ry;
	always_ff @(posedge clk) begin
		ki_s2 <= ki_s1[AW-1:0];
	end
	always_ff @(posedge clk) begin
		dx2 <= 64'(dx) * 64'(dx);
		dy2 <= 64'(dy) * 64'(dy);
	end
	assign dsum = {2'b00, dx2} + {2'b00, dy2};

	assign nxt = {1'b0, (st_q == ST_DIVY) ? cy_q : cx_q} + {1'b0, ursp.res[31:0]};

	// step * 9 / 10 as 9q + (r ? r - 1 : 0), with q = step / 10, r = step % 10
	assign q10_p   = 64'(step_q) * 64'(RECIP10);
	assign q10x10  = {q10_q[28:0], 3'b000} + {q10_q[30:0], 1'b0};
	assign rem10   = step_q - q10x10;
	assign step_nx = {q10_q[28:0], 3'b000} + q10_q + ((rem10 == '0) ? '0 : rem10 - 32'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_LOAD;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			step_q   <= '0;
			ovalid_q <= 1'b0;
			rv_s1    <= 1'b0;
			rv_s2    <= 1'b0;
			ureq     <= '0;
			k_q      <= '0;
			any_q    <= 1'b0;
		end else begin
			ureq.start <= 1'b0;
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			rv_s1 <= 1'b0;
			rv_s2 <= rv_s1;
			case (st_q)
				ST_LOAD: if (acc) begin
					if (cnt_q < CW'(MAX_POINTS)) cnt_q <= cnt_q + CW'(1);
					else ovf_q <= 1'b1;
					if (in_ch.data.last_point) st_q <= ST_MULW;
				end
				ST_MULW: begin
					wsq_q <= 64'(area_w_q) * 64'(area_w_q);
					st_q  <= ST_INIT;
				end
				ST_INIT: begin
					ureq.start  <= 1'b1;
					ureq.is_div <= 1'b0;
					ureq.opa    <= {2'b00, wsq_q} + {2'b00, 64'(area_h_q) * 64'(area_h_q)};
					cx_q <= area_w_q >> 1;
					cy_q <= area_h_q >> 1;
					rounds_q <= 1'b0;
					st_q <= ST_ISQ;
				end
				ST_ISQ: if (ursp.done) begin
					step_q <= ursp.res[32:1];
					k_q    <= '0;
					any_q  <= 1'b0;
					st_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (k_q < cnt_q) begin
						rv_s1 <= 1'b1;
						ki_s1 <= k_q;
						k_q   <= k_q + CW'(1);
					end else if (!rv_s1 && !rv_s2) begin
						ureq.start  <= 1'b1;
						ureq.is_div <= 1'b0;
						ureq.opa    <= any_q ? best_q : '0;
						st_q        <= ST_RSQ;
					end
					if (rv_s2 && (!any_q || dsum > best_q)) begin
						best_q <= dsum;
						bidx_q <= ki_s2;
						any_q  <= 1'b1;
					end
				end
				ST_RSQ: if (ursp.done) begin
					e_q <= ursp.res;
					if (!rounds_q) begin
						rounds_q <= 1'b1;
						if (step_q == '0) begin
							rad_q <= ursp.res[32] ? '1 : ursp.res[31:0];
							st_q <= ST_OUT;
						end else begin
							k_q <= '0; any_q <= 1'b0; st_q <= ST_SCAN;
						end
					end else if (ursp.res == '0) begin
						st_q <= ST_DIV10;
					end else begin
						st_q <= ST_RDP;
					end
				end
				ST_RDP: begin
					bx_q <= rx;
					by_q <= ry;
					mx_q <= 64'(step_q) * 64'((rx > cx_q) ? rx - cx_q : cx_q - rx);
					my_q <= 64'(step_q) * 64'((ry > cy_q) ? ry - cy_q : cy_q - ry);
					st_q <= ST_DIVX;
					ureq.start <= 1'b0;
				end
				ST_DIVX: begin
					if (!ureq.start && !u_busy) begin
						ureq.start  <= 1'b1;
						ureq.is_div <= 1'b1;
						ureq.opa    <= {mx_q, 2'b00};
						ureq.opb    <= e_q;
					end
					if (ursp.done) begin
						if (bx_q > cx_q)
							cx_q <= (ursp.res[63:32] != '0 || nxt[32]) ? '1 : nxt[31:0];
						else
							cx_q <= (ursp.res >= 64'(cx_q)) ? '0 : cx_q - ursp.res[31:0];
						ureq.start  <= 1'b1;
						ureq.is_div <= 1'b1;
						ureq.opa    <= {my_q, 2'b00};
						ureq.opb    <= e_q;
						st_q <= ST_DIVY;
					end
				end
				ST_DIVY: if (ursp.done) begin
					if (by_q > cy_q)
						cy_q <= (ursp.res[63:32] != '0 || nxt[32]) ? '1 : nxt[31:0];
					else
						cy_q <= (ursp.res >= 64'(cy_q)) ? '0 : cy_q - ursp.res[31:0];
					st_q <= ST_DIV10;
				end
				ST_DIV10: begin
					q10_q <= {3'b000, q10_p[63:35]};
					st_q  <= ST_STEP;
				end
				ST_STEP: begin
					step_q <= step_nx;
					rad_q  <= e_q[63:32] != '0 ? '1 : e_q[31:0];
					if (step_nx == '0) st_q <= ST_OUT;
					else begin
						k_q <= '0; any_q <= 1'b0; st_q <= ST_SCAN;
					end
				end
				ST_OUT: if (!ovalid_q) begin
					res_q.center_x <= cx_q;
					res_q.center_y <= cy_q;
					res_q.radius   <= rad_q;
					res_q.points_dropped <= ovf_q;
					ovalid_q <= 1'b1;
					cnt_q <= '0;
					ovf_q <= 1'b0;
					st_q  <= ST_LOAD;
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	// divider start guard: unit is idle when no request pending and state just entered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) divx_go_q <= 1'b0;
		else divx_go_q <= (st_q == ST_DIVX);
	end
	assign u_busy = divx_go_q;

`ifndef SYNTHESIS
	a_no_in_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_LOAD) |-> !in_ch.ready) else $error("input ready during search");
	a_out_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> cnt_q == '0) else $error("store not emptied");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS)) else $error("store count over capacity");
`endif
endmodule
